// ===== hw/rtl/svn_pkg.sv =====
// Shared types, constants and codes for the smooth vertex normals block.
// Depends on nothing; every other RTL file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package svn_pkg;

    localparam int MAX_VERTICES_DEF = 64;

    // request, result and sum field widths
    localparam int IDX_W   = 6;
    localparam int POS_W   = 16;
    localparam int CNT_W   = 7;
    localparam int FUNC_W  = 2;
    localparam int NORM_W  = 16;
    localparam int SUM_W   = 24;

    // unitize operand width (components below 2^40 in magnitude)
    localparam int VIN_W   = 41;

    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TRI    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

    localparam logic signed [SUM_W:0] SUM_MAX = 25'sd8388607;
    localparam logic signed [SUM_W:0] SUM_MIN = -25'sd8388608;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_TRI_RD,
        S_TRI_MUL,
        S_TRI_START,
        S_TRI_NORM,
        S_TRI_ACC,
        S_FIN_RD,
        S_FIN_START,
        S_FIN_NORM,
        S_FIN_OUT
    } state_t;

    typedef enum logic [2:0] {
        U_IDLE,
        U_SHIFT,
        U_SQ,
        U_SQRT,
        U_DIVI,
        U_DIV
    } ustate_t;

    // result of one normalization, handed from the unit to the sequencer
    typedef struct packed {
        logic                     done;
        logic                     zero;
        logic signed [NORM_W-1:0] qx;
        logic signed [NORM_W-1:0] qy;
        logic signed [NORM_W-1:0] qz;
    } uz_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/svn_unitize.sv =====
// Iterative vector normalizer: shift, sum of squares, square root, divide.
// Depends on svn_pkg for widths, state codes and the result struct.
`timescale 1ns / 1ps
`default_nettype none

module svn_unitize (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 start,
    input  wire logic signed [svn_pkg::VIN_W-1:0]     vin_x,
    input  wire logic signed [svn_pkg::VIN_W-1:0]     vin_y,
    input  wire logic signed [svn_pkg::VIN_W-1:0]     vin_z,
    output svn_pkg::uz_res_t                          res
);

    svn_pkg::ustate_t ust_reg, ust_next;
    logic [39:0] m_reg [3];
    logic [39:0] m_next [3];
    logic [2:0]  neg_reg, neg_next;
    logic [61:0] prod_reg, prod_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] sx_reg, sx_next;
    logic [63:0] sr_reg, sr_next;
    logic [63:0] sb_reg, sb_next;
    logic [33:0] rem_reg, rem_next;
    logic [14:0] nl_reg, nl_next;
    logic [14:0] q_reg, q_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [1:0]  comp_reg, comp_next;
    logic signed [15:0] qo_reg [3];
    logic signed [15:0] qo_next [3];
    logic        zero_reg, zero_next;
    logic        done_reg, done_next;

    logic [39:0] mx;
    logic [63:0] st;
    logic [33:0] dt;
    logic [32:0] dd;
    logic signed [40:0] vv [3];
    logic signed [40:0] vmag [3];
    logic [15:0] qpos;

    assign vv[0] = vin_x;
    assign vv[1] = vin_y;
    assign vv[2] = vin_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vmag[i] = vv[i][40] ? -vv[i] : vv[i];
        end
        mx = m_reg[0];
        if (m_reg[1] > mx) mx = m_reg[1];
        if (m_reg[2] > mx) mx = m_reg[2];
        st   = sr_reg + sb_reg;
        dd   = {sr_reg[31:0], 1'b0};
        dt   = {rem_reg[32:0], nl_reg[14]};
        qpos = {1'b0, (dt >= 34'(dd)) ? {q_reg[13:0], 1'b1} : {q_reg[13:0], 1'b0}};
    end

    always_comb begin
        ust_next  = ust_reg;
        m_next    = m_reg;
        neg_next  = neg_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        sx_next   = sx_reg;
        sr_next   = sr_reg;
        sb_next   = sb_reg;
        rem_next  = rem_reg;
        nl_next   = nl_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        comp_next = comp_reg;
        qo_next   = qo_reg;
        zero_next = zero_reg;
        done_next = 1'b0;
        unique case (ust_reg)
            svn_pkg::U_IDLE: begin
                if (start) begin
                    for (int i = 0; i < 3; i++) begin
                        m_next[i]   = vmag[i][39:0];
                        neg_next[i] = vv[i][40];
                    end
                    ust_next = svn_pkg::U_SHIFT;
                end
            end
            svn_pkg::U_SHIFT: begin
                // bring the largest magnitude into [2^30, 2^31)
                priority if (mx == 40'd0) begin
                    qo_next[0] = '0;
                    qo_next[1] = '0;
                    qo_next[2] = '0;
                    zero_next  = 1'b1;
                    done_next  = 1'b1;
                    ust_next   = svn_pkg::U_IDLE;
                end else if (mx[39:31] != '0) begin
                    for (int i = 0; i < 3; i++) m_next[i] = m_reg[i] >> 1;
                end else if (mx[30] == 1'b0) begin
                    for (int i = 0; i < 3; i++) m_next[i] = m_reg[i] << 1;
                end else begin
                    cnt_next = '0;
                    acc_next = '0;
                    ust_next = svn_pkg::U_SQ;
                end
            end
            svn_pkg::U_SQ: begin
                if (cnt_reg[1:0] != 2'd3) begin
                    prod_next = m_reg[cnt_reg[1:0]][30:0] * m_reg[cnt_reg[1:0]][30:0];
                end
                if (cnt_reg != '0) acc_next = acc_reg + 64'(prod_reg);
                if (cnt_reg[1:0] == 2'd3) begin
                    sx_next  = acc_reg + 64'(prod_reg);
                    sr_next  = '0;
                    sb_next  = 64'd1 << 62;
                    cnt_next = '0;
                    ust_next = svn_pkg::U_SQRT;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            svn_pkg::U_SQRT: begin
                if (sx_reg >= st) begin
                    sx_next = sx_reg - st;
                    sr_next = (sr_reg >> 1) + sb_reg;
                end else begin
                    sr_next = sr_reg >> 1;
                end
                sb_next  = sb_reg >> 2;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    comp_next = '0;
                    ust_next  = svn_pkg::U_DIVI;
                end
            end
            svn_pkg::U_DIVI: begin
                // upper part of m*2^15 + len, already below the divisor
                rem_next = 34'(m_reg[comp_reg][30:0]) + 34'(sr_reg[31:15]);
                nl_next  = sr_reg[14:0];
                q_next   = '0;
                cnt_next = '0;
                ust_next = svn_pkg::U_DIV;
            end
            svn_pkg::U_DIV: begin
                rem_next = (dt >= 34'(dd)) ? dt - 34'(dd) : dt;
                q_next   = qpos[14:0];
                nl_next  = {nl_reg[13:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd14) begin
                    qo_next[comp_reg] = neg_reg[comp_reg] ? -$signed(qpos) : $signed(qpos);
                    if (comp_reg == 2'd2) begin
                        zero_next = 1'b0;
                        done_next = 1'b1;
                        ust_next  = svn_pkg::U_IDLE;
                    end else begin
                        comp_next = comp_reg + 2'd1;
                        ust_next  = svn_pkg::U_DIVI;
                    end
                end
            end
            default: ust_next = svn_pkg::U_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ust_reg  <= svn_pkg::U_IDLE;
            done_reg <= 1'b0;
        end else begin
            ust_reg  <= ust_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_reg    <= m_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        sx_reg   <= sx_next;
        sr_reg   <= sr_next;
        sb_reg   <= sb_next;
        rem_reg  <= rem_next;
        nl_reg   <= nl_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        comp_reg <= comp_next;
        qo_reg   <= qo_next;
        zero_reg <= zero_next;
    end

    assign res.done = done_reg;
    assign res.zero = zero_reg;
    assign res.qx   = qo_reg[0];
    assign res.qy   = qo_reg[1];
    assign res.qz   = qo_reg[2];

endmodule

`default_nettype wire

// ===== hw/rtl/smooth_vertex_normals_core.sv =====
// Smooth vertex normals: load, triangle (a degenerate face ends early) and finish requests;
// finish normalizes each vertex's sum (a zero sum ends early) and waits out any result stall,
// all through the shared normalizer (shift, sum of squares, 32-step root, a divide for each
// of the three components), then clears the sums.
// One request at a time; s_tready is low while a request is at work.
// Reset (aresetn low, synchronous) clears control state and starts a sweep that zeroes the
// sum memory; no request is taken until it ends.
// Depends on svn_pkg and svn_unitize.
`timescale 1ns / 1ps
`default_nettype none

module smooth_vertex_normals_core #(
    parameter int MAX_VERTICES = svn_pkg::MAX_VERTICES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // vertex_index[5:0] pos_x[21:6] pos_y[37:22] pos_z[53:38] corner_a[59:54]
    // corner_b[65:60] corner_c[71:66] vertex_count[78:72], zero fill
    input  wire logic [79:0] s_tdata,
    // func[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_vertex[5:0] normal_x[21:6] normal_y[37:22] normal_z[53:38], zero fill
    output logic [55:0]      m_tdata,
    // zero_length[0]
    output logic [0:0]       m_tuser,
    output logic             m_tlast
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int SW = svn_pkg::SUM_W;

    // request fields
    logic [5:0]         f_vi, f_ca, f_cb, f_cc;
    logic [15:0]        f_px, f_py, f_pz;
    logic [6:0]         f_vc;
    assign f_vi = s_tdata[5:0];
    assign f_px = s_tdata[21:6];
    assign f_py = s_tdata[37:22];
    assign f_pz = s_tdata[53:38];
    assign f_ca = s_tdata[59:54];
    assign f_cb = s_tdata[65:60];
    assign f_cc = s_tdata[71:66];
    assign f_vc = s_tdata[78:72];

    svn_pkg::state_t state_reg, state_next;

    // vertex position memory {z, y, x}
    logic [47:0]   pos_mem [MAX_VERTICES];
    logic [47:0]   pos_rd_reg;
    logic [AW-1:0] pos_raddr;
    logic          pos_we;

    // sum memory {z, y, x}
    logic [3*SW-1:0] sum_mem [MAX_VERTICES];
    logic [3*SW-1:0] sum_rd_reg;
    logic [AW-1:0]   sum_raddr, sum_waddr;
    logic            sum_we;
    logic [3*SW-1:0] sum_wdata;

    logic [AW-1:0] ca_reg, ca_next, cb_reg, cb_next, cc_reg, cc_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [2:0]    cnt_reg, cnt_next;
    logic [CW-1:0] v_reg, v_next, vcnt_reg, vcnt_next;
    logic [47:0]   pa_reg, pa_next, pb_reg, pb_next;
    logic signed [16:0] e1_reg [3];
    logic signed [16:0] e1_next [3];
    logic signed [16:0] e2_reg [3];
    logic signed [16:0] e2_next [3];
    logic signed [33:0] prod_reg, prod_next;
    logic signed [35:0] cr_reg [3];
    logic signed [35:0] cr_next [3];
    logic signed [15:0] n_reg [3];
    logic signed [15:0] n_next [3];
    logic signed [16:0] mul_a, mul_b;
    logic signed [16:0] pc_c [3];
    logic signed [16:0] pa_c [3];
    logic signed [16:0] pb_c [3];

    logic        ov_reg, ov_next;
    logic [55:0] od_reg, od_next;
    logic        oz_reg, oz_next;
    logic        ol_reg, ol_next;

    logic               uz_start;
    logic signed [40:0] uz_x, uz_y, uz_z;
    svn_pkg::uz_res_t   uz_res;

    logic [AW-1:0] corner;
    logic          s_acc, m_acc;
    logic [CW-1:0] vc_clamp;

    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] s,
                                              input logic signed [15:0] n);
        logic signed [SW:0] r;
        r = $signed({s[SW-1], s}) + (SW+1)'(n);
        if (r > svn_pkg::SUM_MAX) r = svn_pkg::SUM_MAX;
        if (r < svn_pkg::SUM_MIN) r = svn_pkg::SUM_MIN;
        return r[SW-1:0];
    endfunction

    svn_unitize u_unitize (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (uz_start),
        .vin_x   (uz_x),
        .vin_y   (uz_y),
        .vin_z   (uz_z),
        .res     (uz_res)
    );

    assign s_tready = (state_reg == svn_pkg::S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = ov_reg && m_tready;
    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = oz_reg;
    assign m_tlast  = ol_reg;

    assign vc_clamp = (32'(f_vc) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(f_vc);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pa_c[i] = {pa_reg[16*i+15], pa_reg[16*i +: 16]};
            pb_c[i] = {pb_reg[16*i+15], pb_reg[16*i +: 16]};
            pc_c[i] = {pos_rd_reg[16*i+15], pos_rd_reg[16*i +: 16]};
        end
        unique case (cnt_reg[1:0])
            2'd0:    corner = ca_reg;
            2'd1:    corner = cb_reg;
            default: corner = cc_reg;
        endcase
        // cross product operand pairs, one product a cycle
        unique case (cnt_reg)
            3'd0:    begin mul_a = e1_reg[1]; mul_b = e2_reg[2]; end
            3'd1:    begin mul_a = e1_reg[2]; mul_b = e2_reg[1]; end
            3'd2:    begin mul_a = e1_reg[2]; mul_b = e2_reg[0]; end
            3'd3:    begin mul_a = e1_reg[0]; mul_b = e2_reg[2]; end
            3'd4:    begin mul_a = e1_reg[0]; mul_b = e2_reg[1]; end
            default: begin mul_a = e1_reg[1]; mul_b = e2_reg[0]; end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        ca_next    = ca_reg;
        cb_next    = cb_reg;
        cc_next    = cc_reg;
        clr_next   = clr_reg;
        cnt_next   = cnt_reg;
        v_next     = v_reg;
        vcnt_next  = vcnt_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        e1_next    = e1_reg;
        e2_next    = e2_reg;
        prod_next  = prod_reg;
        cr_next    = cr_reg;
        n_next     = n_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        oz_next    = oz_reg;
        ol_next    = ol_reg;
        pos_we     = 1'b0;
        pos_raddr  = corner;
        sum_raddr  = AW'(v_reg);
        sum_we     = 1'b0;
        sum_waddr  = clr_reg;
        sum_wdata  = '0;
        uz_start   = 1'b0;
        uz_x       = 41'(cr_reg[0]);
        uz_y       = 41'(cr_reg[1]);
        uz_z       = 41'(cr_reg[2]);

        if (m_acc) ov_next = 1'b0;

        unique case (state_reg)
            svn_pkg::S_CLEAR: begin
                // zero one sum entry a cycle
                sum_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_VERTICES - 1)) begin
                    clr_next   = '0;
                    state_next = svn_pkg::S_IDLE;
                end
            end
            svn_pkg::S_IDLE: begin
                if (s_acc) begin
                    priority case (s_tuser)
                        svn_pkg::FUNC_LOAD: begin
                            pos_we = (32'(f_vi) < MAX_VERTICES);
                        end
                        svn_pkg::FUNC_TRI: begin
                            ca_next  = AW'(f_ca);
                            cb_next  = AW'(f_cb);
                            cc_next  = AW'(f_cc);
                            cnt_next = '0;
                            // drop a triangle with a corner beyond the mesh
                            if (32'(f_ca) < MAX_VERTICES && 32'(f_cb) < MAX_VERTICES &&
                                32'(f_cc) < MAX_VERTICES) begin
                                state_next = svn_pkg::S_TRI_RD;
                            end
                        end
                        svn_pkg::FUNC_FINISH: begin
                            vcnt_next  = vc_clamp;
                            v_next     = '0;
                            state_next = (vc_clamp == '0) ? svn_pkg::S_CLEAR
                                                          : svn_pkg::S_FIN_RD;
                        end
                        default: ;
                    endcase
                end
            end
            svn_pkg::S_TRI_RD: begin
                cnt_next = cnt_reg + 3'd1;
                unique case (cnt_reg)
                    3'd1:    pa_next = pos_rd_reg;
                    3'd2:    pb_next = pos_rd_reg;
                    3'd3: begin
                        for (int i = 0; i < 3; i++) begin
                            e1_next[i] = pb_c[i] - pa_c[i];
                            e2_next[i] = pc_c[i] - pa_c[i];
                        end
                        cnt_next   = '0;
                        state_next = svn_pkg::S_TRI_MUL;
                    end
                    default: ;
                endcase
            end
            svn_pkg::S_TRI_MUL: begin
                prod_next = mul_a * mul_b;
                cnt_next  = cnt_reg + 3'd1;
                unique case (cnt_reg)
                    3'd1:    cr_next[0] = 36'(prod_reg);
                    3'd2:    cr_next[0] = cr_reg[0] - 36'(prod_reg);
                    3'd3:    cr_next[1] = 36'(prod_reg);
                    3'd4:    cr_next[1] = cr_reg[1] - 36'(prod_reg);
                    3'd5:    cr_next[2] = 36'(prod_reg);
                    3'd6: begin
                        cr_next[2] = cr_reg[2] - 36'(prod_reg);
                        state_next = svn_pkg::S_TRI_START;
                    end
                    default: ;
                endcase
            end
            svn_pkg::S_TRI_START: begin
                uz_start   = 1'b1;
                state_next = svn_pkg::S_TRI_NORM;
            end
            svn_pkg::S_TRI_NORM: begin
                if (uz_res.done) begin
                    n_next[0] = uz_res.qx;
                    n_next[1] = uz_res.qy;
                    n_next[2] = uz_res.qz;
                    cnt_next  = '0;
                    // a degenerate face adds nothing
                    state_next = uz_res.zero ? svn_pkg::S_IDLE : svn_pkg::S_TRI_ACC;
                end
            end
            svn_pkg::S_TRI_ACC: begin
                // read a corner's sums, then write them back in the following cycle
                sum_raddr = (cnt_reg[2:1] == 2'd0) ? ca_reg :
                            (cnt_reg[2:1] == 2'd1) ? cb_reg : cc_reg;
                sum_waddr = sum_raddr;
                cnt_next  = cnt_reg + 3'd1;
                if (cnt_reg[0]) begin
                    sum_we    = 1'b1;
                    sum_wdata = {sat_add(sum_rd_reg[3*SW-1:2*SW], n_reg[2]),
                                 sat_add(sum_rd_reg[2*SW-1:SW],   n_reg[1]),
                                 sat_add(sum_rd_reg[SW-1:0],      n_reg[0])};
                    if (cnt_reg == 3'd5) state_next = svn_pkg::S_IDLE;
                end
            end
            svn_pkg::S_FIN_RD: begin
                state_next = svn_pkg::S_FIN_START;
            end
            svn_pkg::S_FIN_START: begin
                uz_start   = 1'b1;
                uz_x       = 41'($signed(sum_rd_reg[SW-1:0]));
                uz_y       = 41'($signed(sum_rd_reg[2*SW-1:SW]));
                uz_z       = 41'($signed(sum_rd_reg[3*SW-1:2*SW]));
                state_next = svn_pkg::S_FIN_NORM;
            end
            svn_pkg::S_FIN_NORM: begin
                if (uz_res.done && !ov_reg) begin
                    ov_next    = 1'b1;
                    od_next    = {2'b00, uz_res.qz, uz_res.qy, uz_res.qx, 6'(v_reg)};
                    oz_next    = uz_res.zero;
                    ol_next    = (v_reg + CW'(1) == vcnt_reg);
                    state_next = svn_pkg::S_FIN_OUT;
                end
            end
            svn_pkg::S_FIN_OUT: begin
                // hold until the result is taken, then advance
                if (m_acc) begin
                    v_next = v_reg + CW'(1);
                    state_next = (v_reg + CW'(1) == vcnt_reg) ? svn_pkg::S_CLEAR
                                                              : svn_pkg::S_FIN_RD;
                end
            end
            default: state_next = svn_pkg::S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= svn_pkg::S_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        ca_reg   <= ca_next;
        cb_reg   <= cb_next;
        cc_reg   <= cc_next;
        cnt_reg  <= cnt_next;
        v_reg    <= v_next;
        vcnt_reg <= vcnt_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        e1_reg   <= e1_next;
        e2_reg   <= e2_next;
        prod_reg <= prod_next;
        cr_reg   <= cr_next;
        n_reg    <= n_next;
        od_reg   <= od_next;
        oz_reg   <= oz_next;
        ol_reg   <= ol_next;
    end

    // position memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (pos_we) pos_mem[AW'(f_vi)] <= {f_pz, f_py, f_px};
        pos_rd_reg <= pos_mem[pos_raddr];
    end

    // sum memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
        sum_rd_reg <= sum_mem[sum_raddr];
    end

endmodule

`default_nettype wire
